// ----- src/division_magic_number_generator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for division_magic_number_generator_top
// Clocked property wrappers used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef DIVISION_MAGIC_NUMBER_GENERATOR_TOP_ASSERT_SVH
`define DIVISION_MAGIC_NUMBER_GENERATOR_TOP_ASSERT_SVH

// Check outside reset only.
`define DMNG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define DMNG_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/dmng_pkg.sv -----
// ----------------------------------------------------------------------------
// dmng_pkg
// Widths and constants of the division magic number generator.
// ----------------------------------------------------------------------------
package dmng_pkg;

	localparam int DATA_W  = 32;
	localparam int SHIFT_W = 6;
	localparam int P_W     = 7;
	localparam int CNT_W   = 5;

	localparam logic [DATA_W-1:0] ALL_ONES = 32'hffff_ffff;
	localparam logic [DATA_W-1:0] TWO31    = 32'h8000_0000;
	localparam logic [DATA_W-1:0] MAX31    = 32'h7fff_ffff;

	localparam logic [P_W-1:0]     P_START   = 7'd31;
	localparam logic [P_W-1:0]     P_LIMIT   = 7'd64;
	localparam logic [P_W-1:0]     P_BIAS    = 7'd32;
	localparam logic [SHIFT_W-1:0] SHIFT_MAX = 6'd32;
	localparam logic [CNT_W-1:0]   CNT_LAST  = 5'd31;

	localparam logic MODE_UNSIGNED = 1'b0;
	localparam logic MODE_SIGNED   = 1'b1;

endpackage

// ----- src/dmng_req_if.sv -----
// ----------------------------------------------------------------------------
// dmng_req_if
// Request channel: mode and divisor with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmng_req_if
	import dmng_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [DATA_W-1:0] divisor;

	modport source (output valid, req_type, divisor, input ready);
	modport sink (input valid, req_type, divisor, output ready);
endinterface

// ----- src/dmng_res_if.sv -----
// ----------------------------------------------------------------------------
// dmng_res_if
// Result channel: magic multiplier, post-shift and flags.
// ----------------------------------------------------------------------------
interface dmng_res_if
	import dmng_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  magic;
	logic [SHIFT_W-1:0] shift;
	logic               add_needed;
	logic               valid_res;

	modport source (output valid, magic, shift, add_needed, valid_res, input ready);
	modport sink (input valid, magic, shift, add_needed, valid_res, output ready);
endinterface

// ----- src/division_magic_number_generator_top.sv -----
// ----------------------------------------------------------------------------
// division_magic_number_generator_top
// Magic multiplier and post-shift for division by a 32-bit constant.
// ----------------------------------------------------------------------------
// One request at a time. A request in range takes three passes of a shared
// radix-2 restoring divider (the remainder that sets nc/anc, then 2^31/nc,
// then the divisor quotient), then at most 33 doubling steps, and then it
// loads the result register once that is free. An out-of-range divisor goes
// straight to the result register. The result register lets the next request
// be taken while a finished result still waits on the result channel.
module division_magic_number_generator_top
	import dmng_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	dmng_req_if.sink      req,
	dmng_res_if.source    res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REM,
		ST_DIVN,
		ST_DIVD,
		ST_LOOP,
		ST_WRITE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               mode_q;
	logic               ok_q;
	logic               add_q;
	logic [P_W-1:0]     p_q;
	logic [DATA_W-1:0]  d_q;
	logic [DATA_W-1:0]  nc_q;
	logic [DATA_W-1:0]  q1_q, r1_q, q2_q, r2_q;
	logic [DATA_W-1:0]  div_rem_q, div_quo_q, div_dvs_q;

	logic               res_valid_q;
	logic [DATA_W-1:0]  magic_q;
	logic [SHIFT_W-1:0] shift_q;
	logic               add_needed_q;
	logic               valid_res_q;

	// divider step
	logic [DATA_W:0]    rem_sh, rem_diff;
	logic               div_ge;
	logic [DATA_W-1:0]  rem_nx, quo_nx, nc_nx;

	// doubling step
	logic [DATA_W-1:0]  r1_dbl, r2_dbl, q1_dbl, q2_dbl;
	logic               ge1, ge2, add_hit;
	logic [DATA_W-1:0]  q1_nx, r1_nx, q2_nx, r2_nx, lim;
	logic [P_W-1:0]     p_nx;
	logic               go_on;

	logic               in_range, out_free;

	always_comb begin
		rem_sh   = {div_rem_q, div_quo_q[DATA_W-1]};
		rem_diff = rem_sh - {1'b0, div_dvs_q};
		div_ge   = !rem_diff[DATA_W];
		rem_nx   = div_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
		quo_nx   = {div_quo_q[DATA_W-2:0], div_ge};
		nc_nx    = (mode_q == MODE_SIGNED) ? (MAX31 - rem_nx) : (ALL_ONES - rem_nx);
	end

	always_comb begin
		r1_dbl = r1_q + r1_q;
		r2_dbl = r2_q + r2_q;
		q1_dbl = q1_q + q1_q;
		q2_dbl = q2_q + q2_q;
		if (mode_q == MODE_SIGNED) begin
			ge1     = (r1_dbl >= nc_q);
			r1_nx   = ge1 ? (r1_dbl - nc_q) : r1_dbl;
			ge2     = (r2_dbl >= d_q);
			r2_nx   = ge2 ? (r2_dbl - d_q) : r2_dbl;
			add_hit = 1'b0;
			lim     = d_q - r2_nx;
		end else begin
			ge1     = (r1_q >= (nc_q - r1_q));
			r1_nx   = ge1 ? (r1_dbl - nc_q) : r1_dbl;
			ge2     = ((r2_q + 32'd1) >= (d_q - r2_q));
			r2_nx   = ge2 ? (r2_dbl + 32'd1 - d_q) : (r2_dbl + 32'd1);
			add_hit = ge2 ? (q2_q >= MAX31) : (q2_q >= TWO31);
			lim     = d_q - 32'd1 - r2_nx;
		end
		q1_nx = q1_dbl + {{(DATA_W-1){1'b0}}, ge1};
		q2_nx = q2_dbl + {{(DATA_W-1){1'b0}}, ge2};
		p_nx  = p_q + 7'd1;
		go_on = (p_nx < P_LIMIT) && ((q1_nx < lim) || ((q1_nx == lim) && (r1_nx == '0)));
	end

	assign in_range = (req.divisor >= 32'd2) &&
		((req.req_type == MODE_UNSIGNED) || (req.divisor <= MAX31));
	assign out_free = !res_valid_q || res.ready;

	assign req.ready      = (state_q == ST_IDLE);
	assign res.valid      = res_valid_q;
	assign res.magic      = magic_q;
	assign res.shift      = shift_q;
	assign res.add_needed = add_needed_q;
	assign res.valid_res  = valid_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// the write state reloads the result register itself
			if (res_valid_q && res.ready && (state_q != ST_WRITE)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						mode_q <= req.req_type;
						d_q    <= req.divisor;
						ok_q   <= in_range;
						add_q  <= 1'b0;
						cnt_q  <= '0;
						// first pass: (0 - d) % d unsigned, 2^31 % d signed
						div_rem_q <= '0;
						div_quo_q <= (req.req_type == MODE_SIGNED) ? TWO31 : (32'd0 - req.divisor);
						div_dvs_q <= req.divisor;
						state_q   <= in_range ? ST_REM : ST_WRITE;
					end
				end
				ST_REM, ST_DIVN, ST_DIVD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == CNT_LAST) begin
						div_rem_q <= '0;
						if (state_q == ST_REM) begin
							nc_q      <= nc_nx;
							div_quo_q <= TWO31;
							div_dvs_q <= nc_nx;
							state_q   <= ST_DIVN;
						end else if (state_q == ST_DIVN) begin
							q1_q      <= quo_nx;
							r1_q      <= rem_nx;
							div_quo_q <= (mode_q == MODE_SIGNED) ? TWO31 : MAX31;
							div_dvs_q <= d_q;
							state_q   <= ST_DIVD;
						end else begin
							q2_q    <= quo_nx;
							r2_q    <= rem_nx;
							p_q     <= P_START;
							state_q <= ST_LOOP;
						end
					end else begin
						div_rem_q <= rem_nx;
						div_quo_q <= quo_nx;
					end
				end
				ST_LOOP: begin
					q1_q <= q1_nx;
					r1_q <= r1_nx;
					q2_q <= q2_nx;
					r2_q <= r2_nx;
					p_q  <= p_nx;
					if (add_hit) begin
						add_q <= 1'b1;
					end
					if (!go_on) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					// hold until the result register is free
					if (out_free) begin
						res_valid_q  <= 1'b1;
						valid_res_q  <= ok_q;
						if (ok_q) begin
							magic_q      <= q2_q + 32'd1;
							shift_q      <= SHIFT_W'(p_q - P_BIAS);
							add_needed_q <= add_q;
						end else begin
							magic_q      <= '0;
							shift_q      <= '0;
							add_needed_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`include "division_magic_number_generator_top_assert.svh"

	`DMNG_ASSERT(a_bad_zero,
		res.valid && !res.valid_res |-> {res.magic, res.shift, res.add_needed} == '0,
		"out-of-range result carries nonzero fields")
	`DMNG_ASSERT(a_shift_range, res.valid |-> res.shift <= SHIFT_MAX, "post-shift above 32")
	`DMNG_ASSERT(a_loop_bound, state_q == ST_LOOP |-> p_q < P_LIMIT,
		"doubling loop ran past its limit")
	`DMNG_ASSERT_RST(a_reset_quiet, !arst_n |=> !res.valid && state_q == ST_IDLE,
		"block not quiet in reset")

endmodule

// ----- bench/division_magic_number_generator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// division_magic_number_generator_top_tb
// Drives mode/divisor requests with random gaps and back-pressure, computes
// the expected magic multiplier, post-shift and flags for each request, and
// checks every returned result against them in order.
// ----------------------------------------------------------------------------
module division_magic_number_generator_top_tb;
	import dmng_pkg::*;

	typedef struct packed {
		logic              mode;
		logic [DATA_W-1:0] divisor;
	} magic_req_t;

	typedef struct packed {
		logic [DATA_W-1:0]  magic;
		logic [SHIFT_W-1:0] shift;
		logic               add_needed;
		logic               valid_res;
	} magic_res_t;

	localparam int RANDOM_ITEMS   = 1300;
	localparam int IDLE_MAX       = 10;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int REPORT_MAX     = 10;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              req_valid_r   = 1'b0;
	logic              req_type_r    = MODE_UNSIGNED;
	logic [DATA_W-1:0] req_divisor_r = '0;
	logic              res_ready_r   = 1'b0;

	magic_req_t pending_q[$];
	magic_res_t magic_exp_q[$];

	int unsigned drv_gap   = 0;
	int unsigned mon_gap   = 0;
	bit          drv_burst = 1'b0;
	bit          mon_burst = 1'b0;
	int unsigned hold_left = 0;
	int unsigned res_cnt   = 0;
	int unsigned idle_cycles = 0;
	int unsigned err_cnt = 0;
	int unsigned n_unsigned = 0;
	int unsigned n_signed   = 0;
	int unsigned n_rejected = 0;
	int unsigned n_add      = 0;

	dmng_req_if req_ch();
	dmng_res_if res_ch();

	assign req_ch.valid    = req_valid_r;
	assign req_ch.req_type = req_type_r;
	assign req_ch.divisor  = req_divisor_r;
	assign res_ch.ready    = res_ready_r;

	division_magic_number_generator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	always #1 clk = ~clk;

	// Unsigned magic: multiplier, shift and the add-then-shift indicator.
	function automatic magic_res_t unsigned_magic_calc(logic [DATA_W-1:0] d);
		logic [DATA_W-1:0] nc, q1, r1, q2, r2, lim;
		logic              add;
		int                p;
		magic_res_t        r;
		nc  = ALL_ONES - ((32'd0 - d) % d);
		q1  = TWO31 / nc;
		r1  = TWO31 - q1 * nc;
		q2  = MAX31 / d;
		r2  = MAX31 - q2 * d;
		add = 1'b0;
		p   = int'(P_START);
		do begin
			p++;
			if (r1 >= nc - r1) begin
				q1 = q1 + q1 + 32'd1;
				r1 = r1 + r1 - nc;
			end else begin
				q1 = q1 + q1;
				r1 = r1 + r1;
			end
			if (r2 + 32'd1 >= d - r2) begin
				if (q2 >= MAX31)
					add = 1'b1;
				q2 = q2 + q2 + 32'd1;
				r2 = r2 + r2 + 32'd1 - d;
			end else begin
				if (q2 >= TWO31)
					add = 1'b1;
				q2 = q2 + q2;
				r2 = r2 + r2 + 32'd1;
			end
			lim = d - 32'd1 - r2;
		end while (p < int'(P_LIMIT) && (q1 < lim || (q1 == lim && r1 == '0)));
		r.magic      = q2 + 32'd1;
		r.shift      = SHIFT_W'(p - int'(P_BIAS));
		r.add_needed = add;
		r.valid_res  = 1'b1;
		return r;
	endfunction

	// Signed magic for a positive divisor; no add indicator.
	function automatic magic_res_t signed_magic_calc(logic [DATA_W-1:0] ad);
		logic [DATA_W-1:0] anc, q1, r1, q2, r2, gap;
		int                p;
		magic_res_t        r;
		anc = TWO31 - 32'd1 - (TWO31 % ad);
		q1  = TWO31 / anc;
		r1  = TWO31 - q1 * anc;
		q2  = TWO31 / ad;
		r2  = TWO31 - q2 * ad;
		p   = int'(P_START);
		do begin
			p++;
			q1 = q1 + q1;
			r1 = r1 + r1;
			if (r1 >= anc) begin
				q1 = q1 + 32'd1;
				r1 = r1 - anc;
			end
			q2 = q2 + q2;
			r2 = r2 + r2;
			if (r2 >= ad) begin
				q2 = q2 + 32'd1;
				r2 = r2 - ad;
			end
			gap = ad - r2;
		end while (p < int'(P_LIMIT) && (q1 < gap || (q1 == gap && r1 == '0)));
		r.magic      = q2 + 32'd1;
		r.shift      = SHIFT_W'(p - int'(P_BIAS));
		r.add_needed = 1'b0;
		r.valid_res  = 1'b1;
		return r;
	endfunction

	function automatic magic_res_t compute_magic(logic mode, logic [DATA_W-1:0] d);
		magic_res_t r;
		r = '0;
		if (mode == MODE_UNSIGNED) begin
			if (d >= 32'd2)
				r = unsigned_magic_calc(d);
		end else begin
			if (d >= 32'd2 && d <= MAX31)
				r = signed_magic_calc(d);
		end
		return r;
	endfunction

	// Idle cycles before the next request or result ready; bursts run with no gaps at all.
	function automatic int unsigned idle_draw(inout bit burst);
		if ($urandom_range(0, 39) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, IDLE_MAX);
	endfunction

	task automatic report_mismatch(string what, magic_res_t exp_r, magic_res_t got_r);
		err_cnt++;
		if (err_cnt <= REPORT_MAX) begin
			$display("%0t: %s: expected magic=%h shift=%0d add=%b ok=%b",
				$time, what, exp_r.magic, exp_r.shift, exp_r.add_needed, exp_r.valid_res);
			$display("%0t: %s: got      magic=%h shift=%0d add=%b ok=%b",
				$time, what, got_r.magic, got_r.shift, got_r.add_needed, got_r.valid_res);
		end
	endtask

	always @(posedge clk) begin : driver
		magic_req_t nxt;
		magic_res_t pred;
		logic       v;
		if (arst_n) begin
			v = req_valid_r;
			if (req_valid_r && req_ch.ready) begin
				pred = compute_magic(req_type_r, req_divisor_r);
				magic_exp_q.push_back(pred);
				if (!pred.valid_res)
					n_rejected++;
				else if (req_type_r == MODE_SIGNED)
					n_signed++;
				else
					n_unsigned++;
				if (pred.add_needed)
					n_add++;
				v = 1'b0;
			end
			if (!v && pending_q.size() != 0) begin
				if (drv_gap != 0) begin
					drv_gap--;
				end else begin
					nxt = pending_q.pop_front();
					req_type_r    <= nxt.mode;
					req_divisor_r <= nxt.divisor;
					v = 1'b1;
					drv_gap = idle_draw(drv_burst);
				end
			end
			req_valid_r <= v;
		end
	end

	// Long hold-off on the result side while requests keep coming.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0)
				hold_left <= hold_left - 1;
			else if (res_ch.valid && res_ready_r && (res_cnt == 300 || res_cnt == 900))
				hold_left <= HOLD_CYCLES;
		end
	end

	always @(posedge clk) begin : monitor
		magic_res_t got_r;
		magic_res_t exp_r;
		logic       nr;
		if (arst_n) begin
			if (res_ch.valid && res_ready_r) begin
				got_r.magic      = res_ch.magic;
				got_r.shift      = res_ch.shift;
				got_r.add_needed = res_ch.add_needed;
				got_r.valid_res  = res_ch.valid_res;
				if (magic_exp_q.size() == 0) begin
					report_mismatch("result with no request pending", '0, got_r);
				end else begin
					exp_r = magic_exp_q.pop_front();
					if (got_r.magic !== exp_r.magic || got_r.shift !== exp_r.shift ||
					    got_r.add_needed !== exp_r.add_needed ||
					    got_r.valid_res !== exp_r.valid_res)
						report_mismatch("result mismatch", exp_r, got_r);
				end
				res_cnt <= res_cnt + 1;
				mon_gap = idle_draw(mon_burst);
			end
			if (hold_left != 0) begin
				nr = 1'b0;
			end else if (mon_gap != 0) begin
				nr = 1'b0;
				mon_gap--;
			end else begin
				nr = 1'b1;
			end
			res_ready_r <= nr;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid_r && req_ch.ready) || (res_ch.valid && res_ready_r)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		logic [DATA_W-1:0] dir_unsigned[$];
		logic [DATA_W-1:0] dir_signed[$];
		magic_req_t        item;
		int unsigned       sh;
		dir_unsigned = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd7, 32'd10, 32'd641,
			MAX31, TWO31, TWO31 + 32'd1, ALL_ONES - 32'd1, ALL_ONES};
		dir_signed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd7, 32'h4000_0000,
			MAX31, TWO31, ALL_ONES};
		foreach (dir_unsigned[i])
			pending_q.push_back('{MODE_UNSIGNED, dir_unsigned[i]});
		foreach (dir_signed[i])
			pending_q.push_back('{MODE_SIGNED, dir_signed[i]});
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			item.mode = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0, 1, 2, 3: item.divisor = $urandom();
				4, 5:       item.divisor = $urandom_range(2, 1000);
				6: begin
					sh = $urandom_range(1, 31);
					item.divisor = (32'd1 << sh) + 32'($urandom_range(0, 2)) - 32'd1;
				end
				7: begin
					case ($urandom_range(0, 2))
						0:       item.divisor = MAX31 - 32'($urandom_range(0, 3));
						1:       item.divisor = TWO31 + 32'($urandom_range(0, 3));
						default: item.divisor = ALL_ONES - 32'($urandom_range(0, 3));
					endcase
				end
				8:       item.divisor = $urandom_range(0, 1);
				default: item.divisor = $urandom() >> $urandom_range(0, 28);
			endcase
			// keep most signed requests in range
			if (item.mode == MODE_SIGNED && $urandom_range(0, 3) != 0)
				item.divisor[DATA_W-1] = 1'b0;
			pending_q.push_back(item);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || req_valid_r || magic_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d unsigned, %0d signed, %0d out of range,",
			res_cnt, n_unsigned, n_signed, n_rejected);
		$display("%0d with add fixup; result side held off twice for %0d cycles",
			n_add, HOLD_CYCLES);
		$display("%0d mismatches, %0d left pending", err_cnt, magic_exp_q.size());
		if (err_cnt == 0 && magic_exp_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
